@@ design/sle_pkg.sv @@
// Shared types, codes and default sizes for the sorted list engine.
package sle_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int VALUE_BITS_DEF = 16;
    localparam int CNT_OUT_W      = 5;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic ins;
        logic del;
        logic clr;
    } cmd_t;

endpackage

@@ design/sle_cell.sv @@
// One slot of the sorted chain: holds a value and its valid bit, shifts with its neighbors.
module sle_cell #(
    parameter int VALUE_BITS = sle_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sle_pkg::cmd_t         cmd,
    input  logic [VALUE_BITS-1:0] key,
    input  logic [VALUE_BITS-1:0] left_val,
    input  logic                  left_valid,
    input  logic                  left_lt,
    input  logic [VALUE_BITS-1:0] right_val,
    input  logic                  right_valid,
    output logic [VALUE_BITS-1:0] val,
    output logic                  valid,
    output logic                  lt,
    output logic                  eq
);

    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] val_next;
    logic                  valid_reg;
    logic                  valid_next;

    assign lt    = valid_reg && (val_reg < key);
    assign eq    = valid_reg && (val_reg == key);
    assign val   = val_reg;
    assign valid = valid_reg;

    // Slots holding smaller values never move; everything from the
    // insertion or deletion point onward shifts by one place.
    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (cmd.clr)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.ins && !lt)
        begin
            val_next   = left_lt ? key : left_val;
            valid_next = valid_reg | left_valid;
        end
        else if (cmd.del && !lt)
        begin
            val_next   = right_val;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

@@ design/sorted_list_engine.sv @@
// Sorted list engine: insert, delete, search and clear give their result in the cycle after the beat,
// except a delete of all equal entries, which keeps busy high while the chain drops one entry per cycle
// and gives its result once the drain finds no equal entry left.
// Otherwise a new operation is taken every cycle; results are one-cycle strobes
// that the receiver cannot stall. Reset empties the store (count and valid bits
// cleared); stored values themselves are not reset.
module sorted_list_engine #(
    parameter int CAPACITY   = sle_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = sle_pkg::VALUE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     op,
    input  logic [VALUE_BITS-1:0]          value,
    input  logic                           delete_all,
    output logic                           done,
    output logic [1:0]                     status,
    output logic                           found,
    output logic [sle_pkg::CNT_OUT_W-1:0]  removed,
    output logic [sle_pkg::CNT_OUT_W-1:0]  length
);

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_DRAIN = 1'b1;

    logic                  state_reg;
    logic                  state_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [CW-1:0]         rem_reg;
    logic [CW-1:0]         rem_next;
    logic [VALUE_BITS-1:0] key_reg;
    logic [VALUE_BITS-1:0] key_next;
    logic                  done_reg;
    logic                  done_next;
    logic [1:0]            status_reg;
    logic [1:0]            status_next;
    logic                  found_reg;
    logic                  found_next;
    logic [CW-1:0]         removed_reg;
    logic [CW-1:0]         removed_next;

    sle_pkg::cmd_t         cmd;
    logic [VALUE_BITS-1:0] key;
    logic                  accept;
    logic                  any_eq;
    logic                  full;

    logic [VALUE_BITS-1:0] val_vec   [CAPACITY];
    logic [VALUE_BITS-1:0] left_val  [CAPACITY];
    logic [VALUE_BITS-1:0] right_val [CAPACITY];
    logic [CAPACITY-1:0]   valid_vec;
    logic [CAPACITY-1:0]   left_valid;
    logic [CAPACITY-1:0]   left_lt;
    logic [CAPACITY-1:0]   right_valid;
    logic [CAPACITY-1:0]   lt_vec;
    logic [CAPACITY-1:0]   eq_vec;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign key    = (state_reg == S_IDLE) ? value : key_reg;
    assign any_eq = |eq_vec;
    assign full   = (count_reg == CW'(CAPACITY));

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                // The head slot sees a virtual smaller neighbor, so an insert
                // that passes no entry lands here.
                assign left_val[i]   = '0;
                assign left_valid[i] = 1'b1;
                assign left_lt[i]    = 1'b1;
            end
            else
            begin : g_mid_l
                assign left_val[i]   = val_vec[i-1];
                assign left_valid[i] = valid_vec[i-1];
                assign left_lt[i]    = lt_vec[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign right_val[i]   = '0;
                assign right_valid[i] = 1'b0;
            end
            else
            begin : g_mid_r
                assign right_val[i]   = val_vec[i+1];
                assign right_valid[i] = valid_vec[i+1];
            end

            sle_cell #(
                .VALUE_BITS(VALUE_BITS)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .key        (key),
                .left_val   (left_val[i]),
                .left_valid (left_valid[i]),
                .left_lt    (left_lt[i]),
                .right_val  (right_val[i]),
                .right_valid(right_valid[i]),
                .val        (val_vec[i]),
                .valid      (valid_vec[i]),
                .lt         (lt_vec[i]),
                .eq         (eq_vec[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        rem_next     = rem_reg;
        key_next     = key_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        found_next   = found_reg;
        removed_next = removed_reg;
        cmd          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next    = 1'b1;
                    status_next  = sle_pkg::ST_OK;
                    found_next   = 1'b0;
                    removed_next = '0;
                    unique case (op)
                        sle_pkg::OP_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = sle_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.ins    = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        sle_pkg::OP_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = sle_pkg::ST_EMPTY;
                            end
                            else if (!any_eq)
                            begin
                                status_next = sle_pkg::ST_ABSENT;
                            end
                            else
                            begin
                                cmd.del      = 1'b1;
                                count_next   = count_reg - 1'b1;
                                found_next   = 1'b1;
                                removed_next = CW'(1);
                                if (delete_all)
                                begin
                                    // Remaining equal entries sit right behind;
                                    // drop them one per cycle before reporting.
                                    done_next  = 1'b0;
                                    state_next = S_DRAIN;
                                    rem_next   = CW'(1);
                                    key_next   = value;
                                end
                            end
                        end
                        sle_pkg::OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = sle_pkg::ST_EMPTY;
                            end
                            else if (any_eq)
                            begin
                                found_next = 1'b1;
                            end
                            else
                            begin
                                status_next = sle_pkg::ST_ABSENT;
                            end
                        end
                        sle_pkg::OP_CLEAR:
                        begin
                            cmd.clr    = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            status_next = sle_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_DRAIN:
            begin
                if (any_eq)
                begin
                    cmd.del    = 1'b1;
                    count_next = count_reg - 1'b1;
                    rem_next   = rem_reg + 1'b1;
                end
                else
                begin
                    done_next    = 1'b1;
                    status_next  = sle_pkg::ST_OK;
                    found_next   = 1'b1;
                    removed_next = rem_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        key_reg     <= key_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        removed_reg <= removed_next;
    end

    assign done    = done_reg;
    assign status  = status_reg;
    assign found   = found_reg;
    assign removed = sle_pkg::CNT_OUT_W'(removed_reg);
    assign length  = sle_pkg::CNT_OUT_W'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_valid_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("cell valid bits disagree with entry count");

    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(valid_vec ^ (valid_vec >> 1)) && (valid_vec[CAPACITY-1] == 1'b0
        || valid_vec == {CAPACITY{1'b1}}))
        else $error("valid cells do not form a contiguous head run");

    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_single_beat_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op != sle_pkg::OP_DELETE || !delete_all)) |=> done)
        else $error("result missing one cycle after beat");

endmodule
